### src/cpvc_pkg.sv
// Shared types, constants and helpers for the cascaded position/velocity controller.
`default_nettype none
package cpvc_pkg;

  localparam logic [30:0] ELEV_LIMIT = 31'd13107200;
  localparam logic [30:0] AIL_LIMIT  = 31'd13107200;
  localparam int          TICK_RATE  = 70;
  localparam int          ACC_SHIFT  = 3;

  // Width of the raw acceleration: a 33-bit velocity difference times the tick rate.
  localparam int ACC_W  = 34 + $clog2(TICK_RATE);
  localparam int FDIF_W = ACC_W + 1;

  localparam int GAIN_W = 31;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_POS_KX    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_POS_KI_DT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_POS_KV    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_POS_KA    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_VEL_KI_DT = 3'd4;
  localparam logic [CFG_IW-1:0] REG_VEL_KV    = 3'd5;
  localparam logic [CFG_IW-1:0] REG_VEL_KA    = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SPEED_MAX = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 31'd65536;

  typedef struct packed {
    logic [GAIN_W-1:0] pos_kx;
    logic [GAIN_W-1:0] pos_ki_dt;
    logic [GAIN_W-1:0] pos_kv;
    logic [GAIN_W-1:0] pos_ka;
    logic [GAIN_W-1:0] vel_ki_dt;
    logic [GAIN_W-1:0] vel_kv;
    logic [GAIN_W-1:0] vel_ka;
    logic [GAIN_W-1:0] speed_max;
  } gains_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic signed [31:0] drive;
  } lane_res_t;

  function automatic logic signed [51:0] clamp_sym(input logic signed [51:0] v,
                                                   input logic [30:0] lim);
    logic signed [51:0] l;
    l = signed'({21'd0, lim});
    if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end else begin
      return v;
    end
  endfunction

endpackage
`default_nettype wire

### src/cpvc_lane.sv
// One axis of the controller: a small sequencer around a shared gain multiplier.
`default_nettype none
module cpvc_lane
  import cpvc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               mode,
  input  wire logic signed [31:0] setpoint,
  input  wire logic signed [31:0] position,
  input  wire logic signed [31:0] velocity,
  input  wire gains_t             gains,
  input  wire logic [30:0]        limit,
  input  wire logic               take,
  output lane_res_t               res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KX   = 3'd1;
  localparam logic [2:0] S_KI   = 3'd2;
  localparam logic [2:0] S_KV   = 3'd3;
  localparam logic [2:0] S_KA   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_HOLD = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic signed [31:0]       integ_r, prior_r, filt_r;
  logic signed [33:0]       err_r;
  logic signed [32:0]       diff_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [31:0]       vel_r, vd_r, drive_r;
  logic                     mode_r;
  logic signed [65:0]       prod_r;
  logic signed [51:0]       sum_r;

  logic signed [31:0]       mul_a;
  logic signed [33:0]       mul_b;
  logic signed [65:0]       prod;
  logic signed [49:0]       q;
  logic [GAIN_W-1:0]        ki, kv, ka;
  logic signed [FDIF_W-1:0] fdif;
  logic signed [FDIF_W:0]   fsum;
  logic signed [31:0]       filt_nxt;
  logic [30:0]              half;

  assign ki   = mode_r ? gains.pos_ki_dt : gains.vel_ki_dt;
  assign kv   = mode_r ? gains.pos_kv : gains.vel_kv;
  assign ka   = mode_r ? gains.pos_ka : gains.vel_ka;
  assign half = limit >> 1;
  assign q    = prod_r[65:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_KX: begin
        mul_a = signed'({1'b0, gains.pos_kx});
        mul_b = err_r;
      end
      S_KI: begin
        mul_a = signed'({1'b0, ki});
        mul_b = err_r;
      end
      S_KV: begin
        mul_a = signed'({1'b0, kv});
        mul_b = 34'(vd_r) - 34'(vel_r);
      end
      S_KA: begin
        mul_a = signed'({1'b0, ka});
        mul_b = 34'(filt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    fdif = FDIF_W'(acc_r) - FDIF_W'(filt_r);
    fsum = (FDIF_W + 1)'(filt_r) + (FDIF_W + 1)'(fdif >>> ACC_SHIFT);
    if (fsum > (FDIF_W + 1)'(32'sh7FFFFFFF)) begin
      filt_nxt = 32'sh7FFFFFFF;
    end else if (fsum < (FDIF_W + 1)'(-33'sh080000000)) begin
      filt_nxt = -32'sh80000000;
    end else begin
      filt_nxt = 32'(fsum);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = start ? S_KX : S_IDLE;
      S_KX:    state_nxt = S_KI;
      S_KI:    state_nxt = S_KV;
      S_KV:    state_nxt = S_KA;
      S_KA:    state_nxt = S_FIN;
      S_FIN:   state_nxt = S_HOLD;
      S_HOLD:  state_nxt = take ? S_IDLE : S_HOLD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      integ_r <= '0;
      prior_r <= '0;
      filt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            prior_r <= velocity;
          end
        end
        S_KI:    filt_r <= filt_nxt;
        S_KV:    integ_r <= 32'(clamp_sym(52'(integ_r) + 52'(q), half));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_r <= mode;
          vel_r  <= velocity;
          err_r  <= mode ? 34'(setpoint) - 34'(position) : 34'sd0 - 34'(velocity);
          diff_r <= 33'(velocity) - 33'(prior_r);
        end
      end
      S_KX: begin
        prod_r <= prod;
        acc_r  <= ACC_W'(diff_r) * ACC_W'(TICK_RATE);
      end
      S_KI: begin
        prod_r <= prod;
        vd_r   <= mode_r ? 32'(clamp_sym(52'(q), gains.speed_max)) : 32'sd0;
      end
      S_KV: begin
        prod_r <= prod;
      end
      S_KA: begin
        prod_r <= prod;
        sum_r  <= 52'(q) + 52'(integ_r);
      end
      S_FIN: begin
        drive_r <= 32'(clamp_sym(sum_r - 52'(q), limit));
      end
      default: ;
    endcase
  end

  assign res.idle  = (state_r == S_IDLE);
  assign res.done  = (state_r == S_HOLD);
  assign res.drive = drive_r;

endmodule
`default_nettype wire

### src/cpvc_merge.sv
// Output stage that joins the two lane results into one transaction.
`default_nettype none
module cpvc_merge
  import cpvc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lane_res_t          elev_res,
  input  wire lane_res_t          ail_res,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_elev_drive,
  output logic signed [31:0]      out_ail_drive
);

  logic               valid_r;
  logic signed [31:0] elev_r, ail_r;

  assign take = elev_res.done & ail_res.done & (~valid_r | ~out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      elev_r <= elev_res.drive;
      ail_r  <= ail_res.drive;
    end
  end

  assign out_valid      = valid_r;
  assign out_elev_drive = elev_r;
  assign out_ail_drive  = ail_r;

endmodule
`default_nettype wire

### src/cascaded_position_velocity_controller.sv
// Top level of the two-axis cascaded position/velocity controller.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | position_mode, three Q16.16 values per axis
//   out_    | output    | out_valid / out_stall | elev_drive, ail_drive
//   cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// From acceptance to out_valid each transaction goes through four steps through the
// one multiplier in each lane, then the final clamp, then the hand-over of the result.
// A new transaction is accepted as soon as both lanes have handed over their results,
// so no new transaction is accepted while the lanes still work on the last one.
// rst_n is synchronous; it clears the gains to their defaults and the axis state to zero.
// A stalled output holds its result; the lanes then wait with theirs and in_stall stays high.
`default_nettype none
module cascaded_position_velocity_controller
  import cpvc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_position_mode,
  input  wire logic signed [31:0] in_elev_setpoint,
  input  wire logic signed [31:0] in_elev_position,
  input  wire logic signed [31:0] in_elev_velocity,
  input  wire logic signed [31:0] in_ail_setpoint,
  input  wire logic signed [31:0] in_ail_position,
  input  wire logic signed [31:0] in_ail_velocity,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_elev_drive,
  output logic signed [31:0]      out_ail_drive,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [GAIN_W-1:0]  cfg_data
);

  gains_t    gains_r;
  lane_res_t elev_res, ail_res;
  logic      start, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.pos_kx    <= GAIN_ONE;
      gains_r.pos_ki_dt <= '0;
      gains_r.pos_kv    <= GAIN_ONE;
      gains_r.pos_ka    <= '0;
      gains_r.vel_ki_dt <= '0;
      gains_r.vel_kv    <= GAIN_ONE;
      gains_r.vel_ka    <= '0;
      gains_r.speed_max <= GAIN_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_KX:    gains_r.pos_kx    <= cfg_data;
        REG_POS_KI_DT: gains_r.pos_ki_dt <= cfg_data;
        REG_POS_KV:    gains_r.pos_kv    <= cfg_data;
        REG_POS_KA:    gains_r.pos_ka    <= cfg_data;
        REG_VEL_KI_DT: gains_r.vel_ki_dt <= cfg_data;
        REG_VEL_KV:    gains_r.vel_kv    <= cfg_data;
        REG_VEL_KA:    gains_r.vel_ka    <= cfg_data;
        REG_SPEED_MAX: gains_r.speed_max <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign in_stall = ~(elev_res.idle & ail_res.idle);
  assign start    = in_valid & ~in_stall;

  cpvc_lane u_elev (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .mode     (in_position_mode),
    .setpoint (in_elev_setpoint),
    .position (in_elev_position),
    .velocity (in_elev_velocity),
    .gains    (gains_r),
    .limit    (ELEV_LIMIT),
    .take     (take),
    .res      (elev_res)
  );

  cpvc_lane u_ail (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .mode     (in_position_mode),
    .setpoint (in_ail_setpoint),
    .position (in_ail_position),
    .velocity (in_ail_velocity),
    .gains    (gains_r),
    .limit    (AIL_LIMIT),
    .take     (take),
    .res      (ail_res)
  );

  cpvc_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .elev_res       (elev_res),
    .ail_res        (ail_res),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_elev_drive (out_elev_drive),
    .out_ail_drive  (out_ail_drive)
  );

`ifndef SYNTHESIS
  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (elev_res.idle == ail_res.idle) && (elev_res.done == ail_res.done))
    else $error("Axis lanes out of step.");

  a_accept_starts_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !elev_res.idle && !ail_res.idle)
    else $error("Accepted transaction did not start the lanes.");

  a_output_from_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(take))
    else $error("Output became valid without lane results.");
`endif

endmodule
`default_nettype wire

### sim/tb_cascaded_position_velocity_controller.sv
// Self-checking testbench for the two-axis cascaded position/velocity controller.
module tb_cascaded_position_velocity_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import cpvc_pkg::*;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int PHASES = 8;
  localparam int PHASE_TICKS = 200;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;

  typedef struct {
    bit                 mode;
    logic signed [31:0] e_sp, e_pos, e_vel, a_sp, a_pos, a_vel;
  } tick_t;

  typedef struct {
    logic signed [31:0] elev;
    logic signed [31:0] ail;
  } drive_pair_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_position_mode = 1'b0;
  logic signed [31:0]    in_elev_setpoint = '0;
  logic signed [31:0]    in_elev_position = '0;
  logic signed [31:0]    in_elev_velocity = '0;
  logic signed [31:0]    in_ail_setpoint = '0;
  logic signed [31:0]    in_ail_position = '0;
  logic signed [31:0]    in_ail_velocity = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [31:0]    out_elev_drive;
  logic signed [31:0]    out_ail_drive;
  logic                  cfg_we = 1'b0;
  logic [CFG_IW-1:0]     cfg_index = REG_POS_KX;
  logic [GAIN_W-1:0]     cfg_data = '0;

  cascaded_position_velocity_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_position_mode (in_position_mode),
    .in_elev_setpoint (in_elev_setpoint),
    .in_elev_position (in_elev_position),
    .in_elev_velocity (in_elev_velocity),
    .in_ail_setpoint  (in_ail_setpoint),
    .in_ail_position  (in_ail_position),
    .in_ail_velocity  (in_ail_velocity),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_elev_drive   (out_elev_drive),
    .out_ail_drive    (out_ail_drive),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gains_t gains = '{pos_kx: GAIN_ONE, pos_ki_dt: GAIN_ZERO, pos_kv: GAIN_ONE,
                    pos_ka: GAIN_ZERO, vel_ki_dt: GAIN_ZERO, vel_kv: GAIN_ONE,
                    vel_ka: GAIN_ZERO, speed_max: GAIN_ONE};
  logic signed [31:0] integ_st[2] = '{0, 0};
  logic signed [31:0] prev_vel_st[2] = '{0, 0};
  logic signed [31:0] accel_st[2] = '{0, 0};

  drive_pair_t drive_q[$];
  int mismatches = 0;
  int cycles = 0;
  int stall_left = 0;
  int run_left = 0;
  int calm_left = 0;
  bit cur_mode = 1'b1;
  int walk_pos[2] = '{0, 0};
  int walk_vel[2] = '{0, 0};
  int walk_sp[2] = '{0, 0};

  function automatic logic signed [63:0] q16_mul(input logic [GAIN_W-1:0] g,
                                                 input logic signed [63:0] x);
    logic signed [95:0] gw;
    logic signed [95:0] xw;
    gw = {65'd0, g};
    xw = x;
    return (gw * xw) >>> 16;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [31:0] axis_drive(input int ax, input bit pmode,
                                                    input longint sp, input longint pos,
                                                    input longint vel, input longint lim);
    logic [GAIN_W-1:0] ki, kv, ka;
    longint err, vd, integ, acc, filt, drive;
    ki = pmode ? gains.pos_ki_dt : gains.vel_ki_dt;
    kv = pmode ? gains.pos_kv : gains.vel_kv;
    ka = pmode ? gains.pos_ka : gains.vel_ka;
    if (pmode) begin
      err = sp - pos;
      vd = clamp_to(q16_mul(gains.pos_kx, err), longint'(gains.speed_max));
    end else begin
      err = -vel;
      vd = 0;
    end
    integ = clamp_to(integ_st[ax] + q16_mul(ki, err), lim / 2);
    integ_st[ax] = integ[31:0];
    acc = (vel - prev_vel_st[ax]) * TICK_RATE;
    prev_vel_st[ax] = vel[31:0];
    filt = accel_st[ax];
    filt = filt + ((acc - filt) >>> ACC_SHIFT);
    if (filt > longint'(S_MAX)) filt = S_MAX;
    else if (filt < longint'(S_MIN)) filt = S_MIN;
    accel_st[ax] = filt[31:0];
    drive = q16_mul(kv, vd - vel) + integ - q16_mul(ka, filt);
    drive = clamp_to(drive, lim);
    return drive[31:0];
  endfunction

  function automatic tick_t mk(input bit m, input logic signed [31:0] es, ep, ev,
                               input logic signed [31:0] as, ap, av);
    tick_t t;
    t.mode = m;
    t.e_sp = es;
    t.e_pos = ep;
    t.e_vel = ev;
    t.a_sp = as;
    t.a_pos = ap;
    t.a_vel = av;
    return t;
  endfunction

  function automatic int rand_signed(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [31:0] pick_edge();
    case ($urandom_range(0, 4))
      0: return S_MAX;
      1: return S_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int r;
    if ($urandom_range(0, 19) == 0) cur_mode = ~cur_mode;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      for (int ax = 0; ax < 2; ax++) begin
        walk_vel[ax] = int'(clamp_to(walk_vel[ax] + rand_signed(1 << 15), 1 << 21));
        walk_pos[ax] = int'(clamp_to(walk_pos[ax] + (walk_vel[ax] >>> 4), 1 << 26));
        if ($urandom_range(0, 9) == 0) walk_sp[ax] = rand_signed(1 << 25);
      end
      t = mk(cur_mode, walk_sp[0], walk_pos[0], walk_vel[0],
             walk_sp[1], walk_pos[1], walk_vel[1]);
    end else if (r < 90) begin
      t = mk($urandom_range(0, 1), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom());
    end else begin
      t = mk(cur_mode, pick_edge(), pick_edge(), pick_edge(),
             pick_edge(), pick_edge(), pick_edge());
    end
    return t;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    logic [31:0] w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) w = $urandom_range(0, 1 << 18);
    else if (r < 62) w = '0;
    else if (r < 72) w = {1'b0, GAIN_MAX};
    else if (r < 80) w = {1'b0, GAIN_ONE};
    else w = $urandom();
    return w[GAIN_W-1:0];
  endfunction

  function automatic gains_t rand_gains();
    gains_t g;
    g.pos_kx = rand_gain();
    g.pos_ki_dt = rand_gain();
    g.pos_kv = rand_gain();
    g.pos_ka = rand_gain();
    g.vel_ki_dt = rand_gain();
    g.vel_kv = rand_gain();
    g.vel_ka = rand_gain();
    g.speed_max = rand_gain();
    return g;
  endfunction

  // The sink stalls in bursts, mostly short, with occasional long bursts and long calm runs.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_stall <= 1'b0;
    end else begin
      run_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 6);
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 3);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    drive_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        if (mismatches < 10)
          $display("result with nothing expected: elev %0d ail %0d",
                   out_elev_drive, out_ail_drive);
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        if (out_elev_drive !== want.elev) begin
          if (mismatches < 10)
            $display("elev_drive mismatch: expected %0d got %0d", want.elev, out_elev_drive);
          mismatches++;
        end
        if (out_ail_drive !== want.ail) begin
          if (mismatches < 10)
            $display("ail_drive mismatch: expected %0d got %0d", want.ail, out_ail_drive);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_cascaded_position_velocity_controller: errors");
      $finish;
    end
  end

  task automatic send_tick(input tick_t t);
    drive_pair_t d;
    in_valid <= 1'b1;
    in_position_mode <= t.mode;
    in_elev_setpoint <= t.e_sp;
    in_elev_position <= t.e_pos;
    in_elev_velocity <= t.e_vel;
    in_ail_setpoint <= t.a_sp;
    in_ail_position <= t.a_pos;
    in_ail_velocity <= t.a_vel;
    do @(posedge clk); while (in_stall);
    d.elev = axis_drive(0, t.mode, t.e_sp, t.e_pos, t.e_vel, longint'(ELEV_LIMIT));
    d.ail = axis_drive(1, t.mode, t.a_sp, t.a_pos, t.a_vel, longint'(AIL_LIMIT));
    drive_q.push_back(d);
  endtask

  task automatic src_pause();
    int n;
    int r;
    n = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) calm_left = $urandom_range(20, 60);
      if (r < 55) n = 0;
      else if (r < 85) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 12);
      else n = $urandom_range(30, 80);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_gains(input gains_t g);
    put_reg(REG_POS_KX, g.pos_kx);
    put_reg(REG_POS_KI_DT, g.pos_ki_dt);
    put_reg(REG_POS_KV, g.pos_kv);
    put_reg(REG_POS_KA, g.pos_ka);
    put_reg(REG_VEL_KI_DT, g.vel_ki_dt);
    put_reg(REG_VEL_KV, g.vel_kv);
    put_reg(REG_VEL_KA, g.vel_ka);
    put_reg(REG_SPEED_MAX, g.speed_max);
    cfg_we <= 1'b0;
    gains = g;
  endtask

  task automatic send_list(input tick_t list[$]);
    foreach (list[i]) begin
      send_tick(list[i]);
      src_pause();
    end
  endtask

  // Default gains: large errors hit the speed clamp, velocity swings saturate the filter.
  task automatic test_reset_gains();
    tick_t list[$];
    list.push_back(mk(1, 0, 0, 0, 0, 0, 0));
    list.push_back(mk(1, S_MAX, S_MIN, 0, S_MIN, S_MAX, 0));
    list.push_back(mk(1, 32'sd65536, 0, S_MAX, -32'sd65536, 0, S_MIN));
    list.push_back(mk(0, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX));
    list.push_back(mk(0, 0, 0, S_MAX, 0, 0, S_MIN));
    list.push_back(mk(0, -32'sd1, -32'sd1, -32'sd1, 32'sd1, 32'sd1, 32'sd1));
    list.push_back(mk(1, -32'sd1, 0, -32'sd3, 32'sd3, 0, 32'sd1));
    list.push_back(mk(1, 32'sd100000, 32'sd99999, 0, -32'sd100000, -32'sd99999, 0));
    send_list(list);
  endtask

  // Full-scale gains drive the integrator and the output into both clamps.
  task automatic test_max_gains();
    tick_t list[$];
    drain();
    load_gains('{default: GAIN_MAX});
    list.push_back(mk(1, S_MAX, S_MIN, 0, S_MIN, S_MAX, 0));
    list.push_back(mk(1, S_MAX, S_MIN, 0, S_MIN, S_MAX, 0));
    list.push_back(mk(0, 0, 0, S_MIN, 0, 0, S_MAX));
    list.push_back(mk(0, 0, 0, S_MAX, 0, 0, S_MIN));
    list.push_back(mk(1, 0, 0, 0, 0, 0, 0));
    list.push_back(mk(1, 32'sd1, 0, -32'sd1, -32'sd1, 0, 32'sd1));
    list.push_back(mk(0, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
    list.push_back(mk(1, S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN));
    send_list(list);
  endtask

  // All gains and the speed limit at zero leave only the integrator state.
  task automatic test_zero_gains();
    tick_t list[$];
    drain();
    load_gains('{default: GAIN_ZERO});
    list.push_back(mk(1, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
    list.push_back(mk(0, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX));
    list.push_back(mk(1, 32'sd12345, -32'sd54321, 32'sd777, -32'sd9, 32'sd8, -32'sd7));
    list.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    send_list(list);
  endtask

  task automatic test_random();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      load_gains(rand_gains());
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if ($urandom_range(0, 99) == 0) drain();
        send_tick(rand_tick());
        src_pause();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_gains();
    test_max_gains();
    test_zero_gains();
    test_random();
    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_cascaded_position_velocity_controller: clean");
    end else begin
      $display("tb_cascaded_position_velocity_controller: errors");
    end
    $finish;
  end

endmodule
